/* src/ppmcd_pkg.sv */
// ppmcd_pkg: shared constants, codes and types of the ppm channel decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps

package ppmcd_pkg;

    // default number of channels in one frame
    localparam int CHANNEL_COUNT_DEF = 8;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_GAP    = 1'b1;

    // configuration reset values
    localparam logic [10:0] SCALE_LIMIT_RST = 11'd500;
    localparam logic [15:0] SYNC_GAP_RST    = 16'd3000;

    // pulse limits in microseconds
    localparam logic [10:0] PULSE_MIN = 11'd1000;
    localparam logic [10:0] PULSE_MAX = 11'd2000;
    localparam logic [10:0] SWITCH_ON = 11'd1950;
    localparam logic [11:0] LINK_MIN  = 12'd900;
    localparam logic [11:0] LINK_MAX  = 12'd2100;

    // frame positions and fixed channel slots
    localparam logic [3:0] POS_START    = 4'd0;
    localparam logic [3:0] POS_FIRST    = 4'd1;
    localparam logic [3:0] CH_THROTTLE  = 4'd3;
    localparam logic [3:0] CH_ARM       = 4'd5;
    localparam logic [3:0] CH_ANGLE     = 4'd6;
    localparam logic [3:0] SLOT_SYNC    = 4'd0;

    // ceil(2^32 / 1000): product of up to 22 bits divided by 1000 exactly
    localparam int          RECIP_SHIFT = 32;
    localparam logic [22:0] RECIP_1000  = 23'd4294968;

    // result of the frame tracker for one event
    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] width;
        logic [9:0]  chan_off;
        logic        is_chan;
        logic [10:0] throttle;
        logic        armed;
        logic        angle;
        logic        connected;
    } t_frame_res;

endpackage

/* src/ppmcd_frame.sv */
// ppmcd_frame: frame position tracking, gap measurement and channel status
// depends on ppmcd_pkg
`timescale 1ns / 1ps

module ppmcd_frame import ppmcd_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [31:0] i_event_time,
    input  logic        i_pin_high,
    input  logic [15:0] i_sync_gap_us,
    output t_frame_res  o_res
);

    localparam logic [3:0] LP_CH_LAST  = 4'(CHANNEL_COUNT);
    localparam logic [3:0] LP_SYNC_POS = 4'(CHANNEL_COUNT + 1);
    localparam logic [3:0] LP_WAIT_POS = 4'(CHANNEL_COUNT + 2);
    localparam logic [3:0] LP_NO_SLOT  = 4'(CHANNEL_COUNT + 1);

    logic [31:0] r_last;
    logic [3:0]  r_pos;
    logic [10:0] r_throttle;
    logic        r_armed;
    logic        r_angle;

    logic [31:0] n_last;
    logic [3:0]  n_pos;
    logic [10:0] n_throttle;
    logic        n_armed;
    logic        n_angle;

    logic [31:0] gap;
    logic [10:0] clamped;
    logic [15:0] sync_sat;

    // gap since the previous rising edge, clamped and saturated forms
    always_comb begin
        gap = i_event_time - r_last;
        if (gap < 32'(PULSE_MIN)) begin
            clamped = PULSE_MIN;
        end else if (gap > 32'(PULSE_MAX)) begin
            clamped = PULSE_MAX;
        end else begin
            clamped = gap[10:0];
        end
        sync_sat = (|gap[31:16]) ? 16'hFFFF : gap[15:0];
    end

    // next frame position, slot written and status
    always_comb begin
        n_last         = r_last;
        n_pos          = r_pos;
        n_throttle     = r_throttle;
        n_armed        = r_armed;
        n_angle        = r_angle;
        o_res.slot     = LP_NO_SLOT;
        o_res.width    = 16'd0;
        o_res.chan_off = 10'd0;
        o_res.is_chan  = 1'b0;
        if (i_pin_high) begin
            n_last = i_event_time;
            if (r_pos == POS_START) begin
                n_pos = POS_FIRST;
            end else begin
                if (r_pos <= LP_CH_LAST) begin
                    o_res.slot     = r_pos;
                    o_res.width    = 16'(clamped);
                    o_res.chan_off = 10'(clamped - PULSE_MIN);
                    o_res.is_chan  = 1'b1;
                    n_pos          = r_pos + 4'd1;
                    if (r_pos == CH_THROTTLE) begin
                        n_throttle = clamped;
                    end
                    if (r_pos == CH_ARM) begin
                        n_armed = (clamped > SWITCH_ON);
                    end
                    if (r_pos == CH_ANGLE) begin
                        n_angle = (clamped > SWITCH_ON);
                    end
                end else if (r_pos == LP_SYNC_POS) begin
                    o_res.slot  = SLOT_SYNC;
                    o_res.width = sync_sat;
                    n_pos       = LP_WAIT_POS;
                end else begin
                    // sync already seen without a long gap: hold until one comes
                    n_pos = LP_WAIT_POS;
                end
                if (gap > 32'(i_sync_gap_us)) begin
                    n_pos = POS_FIRST;
                end
            end
        end
        o_res.throttle  = n_throttle;
        o_res.armed     = n_armed;
        o_res.angle     = n_angle;
        o_res.connected = (12'(n_throttle) >= LINK_MIN) && (12'(n_throttle) <= LINK_MAX);
    end

    // frame state, updated as each event leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= 32'd0;
            r_pos      <= POS_START;
            r_throttle <= 11'd0;
            r_armed    <= 1'b0;
            r_angle    <= 1'b0;
        end else if (i_load) begin
            r_last     <= n_last;
            r_pos      <= n_pos;
            r_throttle <= n_throttle;
            r_armed    <= n_armed;
            r_angle    <= n_angle;
        end
    end

endmodule

/* src/ppmcd_scale.sv */
// ppmcd_scale: maps a channel width onto plus or minus the scale limit
// depends on ppmcd_pkg; product stage here, reciprocal divide feeds the output register
`timescale 1ns / 1ps

module ppmcd_scale import ppmcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [9:0]         i_chan_off,
    input  logic               i_is_chan,
    input  logic [10:0]        i_scale_limit,
    output logic signed [11:0] o_scaled
);

    logic [21:0] r_prod;
    logic        r_is_chan;
    logic [21:0] n_prod;
    logic [44:0] recip;
    logic [11:0] quot;

    // (width - 1000) * 2 * limit
    assign n_prod = 22'(i_chan_off) * 22'({i_scale_limit, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod    <= n_prod;
            r_is_chan <= i_is_chan;
        end
    end

    // divide by 1000 through the reciprocal, then centre on zero
    always_comb begin
        recip    = 45'(r_prod) * 45'(RECIP_1000);
        quot     = recip[RECIP_SHIFT+11:RECIP_SHIFT];
        o_scaled = r_is_chan ? $signed(quot - {1'b0, i_scale_limit}) : 12'sd0;
    end

endmodule

/* src/ppm_channel_decoder.sv */
// ppm_channel_decoder: top level of the ppm channel decoder
// depends on ppmcd_pkg, ppmcd_frame and ppmcd_scale
`timescale 1ns / 1ps

// Decodes an RC PPM pulse train from pin-change events. Every event request gives
// exactly one result: the slot written (0 sync, 1..CHANNEL_COUNT channels,
// CHANNEL_COUNT+1 none), its width, the width scaled to plus or minus scale_limit,
// and the throttle, armed, angle and connected status after the event. One event
// is taken every clock cycle while the output is not stalled; each request moves
// through the input, frame result, product and output registers. The rate is set
// by the frame tracker, which updates its position and last edge time in the
// single cycle an event leaves the input register. Behind it a product stage and
// a reciprocal divide stage complete the scaling. Configuration is written through
// a plain write port and must only change while the decoder is empty.

module ppm_channel_decoder import ppmcd_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [31:0]            i_event_time,
    input  logic                   i_pin_high,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [3:0]             o_channel_index,
    output logic [15:0]            o_pulse_width_us,
    output logic signed [11:0]     o_scaled_value,
    output logic [15:0]            o_throttle_us,
    output logic                   o_armed,
    output logic                   o_angle_mode,
    output logic                   o_connected
);

    logic [10:0] r_scale_limit;
    logic [15:0] r_sync_gap_us;

    logic        r_s1_valid;
    logic [31:0] r_s1_time;
    logic        r_s1_pin;
    logic        r_s2_valid;
    t_frame_res  r_s2_res;
    logic        r_s3_valid;
    t_frame_res  r_s3_res;
    logic        r_o_valid;
    t_frame_res  r_o_res;
    logic signed [11:0] r_o_scaled;

    logic        rdy_o;
    logic        rdy_s3;
    logic        rdy_s2;
    logic        rdy_s1;
    logic        frame_load;
    t_frame_res  frame_res;
    logic signed [11:0] scaled;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_limit <= SCALE_LIMIT_RST;
            r_sync_gap_us <= SYNC_GAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE_LIMIT: r_scale_limit <= i_cfg_data[10:0];
                CFG_SYNC_GAP:    r_sync_gap_us <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when empty or when it moves on
    assign rdy_o      = !r_o_valid || !i_out_stall;
    assign rdy_s3     = !r_s3_valid || rdy_o;
    assign rdy_s2     = !r_s2_valid || rdy_s3;
    assign rdy_s1     = !r_s1_valid || rdy_s2;
    assign o_in_stall = !rdy_s1;
    assign frame_load = r_s1_valid && rdy_s2;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (rdy_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (rdy_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (rdy_o) begin
                r_o_valid <= r_s3_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1_time <= i_event_time;
            r_s1_pin  <= i_pin_high;
        end
    end

    ppmcd_frame #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (frame_load),
        .i_event_time  (r_s1_time),
        .i_pin_high    (r_s1_pin),
        .i_sync_gap_us (r_sync_gap_us),
        .o_res         (frame_res)
    );

    // frame result carried alongside the scaling stages
    always_ff @(posedge i_clk) begin
        if (rdy_s2) begin
            r_s2_res <= frame_res;
        end
        if (rdy_s3) begin
            r_s3_res <= r_s2_res;
        end
        if (rdy_o) begin
            r_o_res    <= r_s3_res;
            r_o_scaled <= scaled;
        end
    end

    ppmcd_scale u_scale (
        .i_clk         (i_clk),
        .i_load        (rdy_s3),
        .i_chan_off    (r_s2_res.chan_off),
        .i_is_chan     (r_s2_res.is_chan),
        .i_scale_limit (r_scale_limit),
        .o_scaled      (scaled)
    );

    // result ports
    assign o_out_valid      = r_o_valid;
    assign o_channel_index  = r_o_res.slot;
    assign o_pulse_width_us = r_o_res.width;
    assign o_scaled_value   = r_o_scaled;
    assign o_throttle_us    = 16'(r_o_res.throttle);
    assign o_armed          = r_o_res.armed;
    assign o_angle_mode     = r_o_res.angle;
    assign o_connected      = r_o_res.connected;

endmodule

/* src/ppmcd_checker.sv */
// ppmcd_checker: port-level assertions for the ppm channel decoder
// depends on ppmcd_pkg; bound to ppm_channel_decoder at the end of this file
`timescale 1ns / 1ps

module ppmcd_checker import ppmcd_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [3:0]         o_channel_index,
    input logic [15:0]        o_pulse_width_us,
    input logic signed [11:0] o_scaled_value,
    input logic [15:0]        o_throttle_us,
    input logic               o_connected
);

    localparam logic [3:0] LP_NO_SLOT = 4'(CHANNEL_COUNT + 1);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_channel_index)
            && $stable(o_pulse_width_us) && $stable(o_scaled_value))
        else $error("result changed while stalled");

    // channel slots carry a clamped width, no slot carries nothing
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_channel_index != SLOT_SYNC) |->
            ((o_channel_index == LP_NO_SLOT) && (o_pulse_width_us == 16'd0))
            || ((o_channel_index <= 4'(CHANNEL_COUNT))
                && (o_pulse_width_us >= 16'(PULSE_MIN))
                && (o_pulse_width_us <= 16'(PULSE_MAX))))
        else $error("slot index or width out of range");

    // only channel slots get a scaled value
    a_scaled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_channel_index == SLOT_SYNC) || (o_channel_index == LP_NO_SLOT))
            |-> (o_scaled_value == 12'sd0))
        else $error("scaled value on a non-channel slot");

    // link status follows the throttle width
    a_connected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_connected == ((o_throttle_us >= 16'(LINK_MIN))
            && (o_throttle_us <= 16'(LINK_MAX))))
        else $error("connected flag disagrees with throttle");

endmodule

bind ppm_channel_decoder ppmcd_checker #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
) u_ppmcd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_channel_index  (o_channel_index),
    .o_pulse_width_us (o_pulse_width_us),
    .o_scaled_value   (o_scaled_value),
    .o_throttle_us    (o_throttle_us),
    .o_connected      (o_connected)
);
